### sv/cspl_pkg.sv
// Shared types and constants of the cubic spline curve evaluator.
`default_nettype none

package cspl_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_WRITE_KNOT = 2'd0,
        CMD_WRITE_COEF = 2'd1,
        CMD_EVAL       = 2'd2,
        CMD_SET_COUNT  = 2'd3
    } cmd_t;

    // Evaluation sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_LO,
        ST_RD_HI,
        ST_CHECK,
        ST_SEARCH,
        ST_CMP,
        ST_DX,
        ST_C3,
        ST_MUL,
        ST_ADD,
        ST_DONE
    } state_t;

    // Beat layouts
    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 1;

    localparam int CURVE_LSB = 0;
    localparam int CURVE_W   = 2;
    localparam int INDEX_LSB = 2;
    localparam int INDEX_W   = 3;
    localparam int POWER_LSB = 5;
    localparam int POWER_W   = 2;
    localparam int VALUE_LSB = 7;
    localparam int VALUE_W   = 32;
    localparam int POS_LSB   = 39;
    localparam int POS_W     = 16;

    // Arithmetic
    localparam int KNOT_W  = 16;
    localparam int COEF_W  = 32;
    localparam int DX_W    = 17;
    localparam int PROD_W  = 49;
    localparam int SHIFT_W = 37;
    localparam int SUM_W   = 38;
    localparam int FRAC_POS = 12;

    localparam logic [POWER_W-1:0] POW_TOP  = 2'd3;
    localparam logic [POWER_W-1:0] POW_NEXT = 2'd2;
    localparam logic [POWER_W-1:0] POW_LAST = 2'd0;

    localparam logic signed [SUM_W-1:0] SAT_HI = 38'sh00_7FFF_FFFF;
    localparam logic signed [SUM_W-1:0] SAT_LO = 38'sh3F_8000_0000;
    localparam logic [COEF_W-1:0] RES_MAX = 32'h7FFF_FFFF;
    localparam logic [COEF_W-1:0] RES_MIN = 32'h8000_0000;

endpackage

`default_nettype wire

### sv/cubic_spline_curve_evaluator.sv
// Top level of the piecewise cubic spline curve evaluator.
`default_nettype none

// The block stores NUM_CURVES piecewise cubic curves and evaluates them on
// request. Every input beat carries a command in s_tuser: write a knot
// position, write one segment coefficient, set a curve's knot count, or
// evaluate a curve at a position. Every beat, of any command, yields exactly
// one output beat: the Q24.8 value in m_tdata and the in_range flag in
// m_tuser. Writes always answer 0 with in_range clear; an evaluation answers
// 0 with in_range clear when the curve does not exist, has fewer than two
// knots, or the position lies outside its first to last knot. Otherwise the
// segment whose knot is the largest one strictly below the position (segment
// 0 at the first knot) is chosen by binary search, and the cubic is evaluated
// in Horner form with floor truncation and saturation at every step. Knots
// and coefficients live in two single-port-read RAMs and are undefined until
// written; knot counts are flip-flops cleared by reset. Items are handled one
// at a time. A write is answered straight from the idle state. The search
// walks the knot RAM one read per step, and one shared multiplier is reused
// for the three Horner steps. An evaluation is rejected on acceptance when
// the curve does not exist or has too few knots, or after reading its first
// and last knot when the position is out of range. A new beat is taken only
// when the output register is empty or its result is being taken.
module cubic_spline_curve_evaluator
    import cspl_pkg::*;
#(
    parameter int NUM_CURVES = 4,
    parameter int MAX_KNOTS  = 8
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Input beat
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // s_tdata, lowest bit up: curve[1:0], entry_index[4:2], coef_power[6:5],
    // write_value[38:7], position[54:39], zero[55]
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [S_TUSER_W-1:0] s_tuser,
    // Result beat
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // m_tdata: curve_value[31:0]
    output logic      [M_TDATA_W-1:0] m_tdata,
    // m_tuser: in_range[0]
    output logic      [M_TUSER_W-1:0] m_tuser
);

    // Address and index widths
    localparam int CI_W   = (NUM_CURVES > 1) ? $clog2(NUM_CURVES) : 1;
    localparam int KI_W   = $clog2(MAX_KNOTS);
    localparam int CNT_W  = $clog2(MAX_KNOTS + 1);
    localparam int KDEPTH = NUM_CURVES * MAX_KNOTS;
    localparam int KA_W   = $clog2(KDEPTH);
    localparam int CDEPTH = KDEPTH * 4;
    localparam int CA_W   = KA_W + POWER_W;

    // Input fields
    cmd_t                       in_cmd;
    logic [CURVE_W-1:0]         in_curve;
    logic [INDEX_W-1:0]         in_index;
    logic [POWER_W-1:0]         in_power;
    logic [VALUE_W-1:0]         in_value;
    logic [POS_W-1:0]           in_pos;

    assign in_cmd   = cmd_t'(s_tuser);
    assign in_curve = s_tdata[CURVE_LSB +: CURVE_W];
    assign in_index = s_tdata[INDEX_LSB +: INDEX_W];
    assign in_power = s_tdata[POWER_LSB +: POWER_W];
    assign in_value = s_tdata[VALUE_LSB +: VALUE_W];
    assign in_pos   = s_tdata[POS_LSB +: POS_W];

    logic                       accept;
    logic                       curve_ok;
    logic                       index_ok;
    logic [CI_W-1:0]            in_cidx;
    logic [KA_W-1:0]            in_base;
    logic [KA_W-1:0]            in_kaddr;
    logic [CNT_W-1:0]           in_count;
    logic [CNT_W-1:0]           clamp_count;

    // Sequencer registers
    state_t                     state_reg, state_next;
    logic [KA_W-1:0]            base_reg, base_next;
    logic [KI_W-1:0]            last_reg, last_next;
    logic [KI_W-1:0]            head_reg, head_next;
    logic [KI_W-1:0]            tail_reg, tail_next;
    logic [KI_W-1:0]            mid_reg, mid_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic [KNOT_W-1:0]          klo_reg, klo_next;
    logic signed [DX_W-1:0]     dx_reg, dx_next;
    logic signed [COEF_W-1:0]   acc_reg, acc_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic [POWER_W-1:0]         pw_reg, pw_next;
    logic                       ok_reg, ok_next;

    // Output register
    logic                       m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]       m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]       m_tuser_reg, m_tuser_next;

    // Knot counts, cleared by reset
    logic [CNT_W-1:0]           count_reg [NUM_CURVES];

    // Memory ports
    logic                       knot_we;
    logic                       knot_re;
    logic [KA_W-1:0]            knot_raddr;
    logic [KNOT_W-1:0]          knot_rdata;
    logic                       coef_we;
    logic                       coef_re;
    logic [CA_W-1:0]            coef_waddr;
    logic [CA_W-1:0]            coef_raddr;
    logic [COEF_W-1:0]          coef_rdata;

    // Datapath
    logic [KI_W-1:0]            mid_calc;
    logic signed [SHIFT_W-1:0]  prod_sh;
    logic signed [SUM_W-1:0]    sum_wide;
    logic signed [COEF_W-1:0]   sum_sat;
    logic                       out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    assign curve_ok = 32'(in_curve) < NUM_CURVES;
    assign index_ok = 32'(in_index) < MAX_KNOTS;
    assign in_cidx  = CI_W'(in_curve);
    assign in_base  = KA_W'(32'(in_curve) * MAX_KNOTS);
    assign in_kaddr = in_base + KA_W'(in_index);
    assign in_count = curve_ok ? count_reg[in_cidx] : '0;

    // Clamp the requested count to 0..MAX_KNOTS; negative values give zero
    always_comb
    begin
        if (in_value[VALUE_W-1])
        begin
            clamp_count = '0;
        end
        else if (in_value > VALUE_W'(MAX_KNOTS))
        begin
            clamp_count = CNT_W'(MAX_KNOTS);
        end
        else
        begin
            clamp_count = CNT_W'(in_value);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CURVES; i++)
            begin
                count_reg[i] <= '0;
            end
        end
        else if (accept && in_cmd == CMD_SET_COUNT && curve_ok)
        begin
            count_reg[in_cidx] <= clamp_count;
        end
    end

    // Memory write side
    assign knot_we    = accept && in_cmd == CMD_WRITE_KNOT && curve_ok && index_ok;
    assign coef_we    = accept && in_cmd == CMD_WRITE_COEF && curve_ok && index_ok;
    assign coef_waddr = {in_kaddr, in_power};

    // Search midpoint: one above the lower middle of head..tail
    assign mid_calc = KI_W'((({1'b0, head_reg} + {1'b0, tail_reg}) >> 1) + 1'b1);

    // Knot read address by state
    always_comb
    begin
        knot_re    = 1'b0;
        knot_raddr = base_reg;
        case (state_reg)
            ST_RD_LO:
            begin
                knot_re    = 1'b1;
                knot_raddr = base_reg;
            end
            ST_RD_HI:
            begin
                knot_re    = 1'b1;
                knot_raddr = base_reg + KA_W'(last_reg);
            end
            ST_SEARCH:
            begin
                knot_re    = 1'b1;
                knot_raddr = (head_reg < tail_reg) ? base_reg + KA_W'(mid_calc)
                                                   : base_reg + KA_W'(head_reg);
            end
            default:
            begin
                knot_re    = 1'b0;
                knot_raddr = base_reg;
            end
        endcase
    end

    // Coefficient read: top power when the segment is settled, then the rest
    assign coef_re    = (state_reg == ST_DX) || (state_reg == ST_MUL);
    assign coef_raddr = {base_reg + KA_W'(head_reg),
                         (state_reg == ST_DX) ? POW_TOP : pw_reg};

    // Horner step: floor shift, add coefficient, saturate
    assign prod_sh  = SHIFT_W'(prod_reg >>> FRAC_POS);
    assign sum_wide = SUM_W'(prod_sh) + SUM_W'($signed(coef_rdata));

    always_comb
    begin
        if (sum_wide > SAT_HI)
        begin
            sum_sat = $signed(RES_MAX);
        end
        else if (sum_wide < SAT_LO)
        begin
            sum_sat = $signed(RES_MIN);
        end
        else
        begin
            sum_sat = sum_wide[COEF_W-1:0];
        end
    end

    cspl_ram #(
        .WIDTH (KNOT_W),
        .DEPTH (KDEPTH)
    ) u_knot_ram (
        .clk   (clk),
        .we    (knot_we),
        .waddr (in_kaddr),
        .wdata (in_value[KNOT_W-1:0]),
        .re    (knot_re),
        .raddr (knot_raddr),
        .rdata (knot_rdata)
    );

    cspl_ram #(
        .WIDTH (COEF_W),
        .DEPTH (CDEPTH)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (coef_waddr),
        .wdata (in_value),
        .re    (coef_re),
        .raddr (coef_raddr),
        .rdata (coef_rdata)
    );

    // Next state and datapath
    always_comb
    begin
        state_next    = state_reg;
        base_next     = base_reg;
        last_next     = last_reg;
        head_next     = head_reg;
        tail_next     = tail_reg;
        mid_next      = mid_reg;
        pos_next      = pos_reg;
        klo_next      = klo_reg;
        dx_next       = dx_reg;
        acc_next      = acc_reg;
        prod_next     = prod_reg;
        pw_next       = pw_reg;
        ok_next       = ok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // Drain the output register
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    base_next = in_base;
                    last_next = KI_W'(in_count - 1'b1);
                    pos_next  = in_pos;
                    if (in_cmd == CMD_EVAL)
                    begin
                        if (curve_ok && in_count >= CNT_W'(2))
                        begin
                            state_next = ST_RD_LO;
                        end
                        else
                        begin
                            ok_next    = 1'b0;
                            state_next = ST_DONE;
                        end
                    end
                    else
                    begin
                        // Writes answer at once
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = '0;
                    end
                end
            end
            ST_RD_LO:
            begin
                state_next = ST_RD_HI;
            end
            ST_RD_HI:
            begin
                klo_next   = knot_rdata;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (pos_reg < klo_reg || pos_reg > knot_rdata)
                begin
                    ok_next    = 1'b0;
                    state_next = ST_DONE;
                end
                else
                begin
                    head_next  = '0;
                    tail_next  = last_reg;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (head_reg < tail_reg)
                begin
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end
                else
                begin
                    state_next = ST_DX;
                end
            end
            ST_CMP:
            begin
                if (pos_reg <= knot_rdata)
                begin
                    tail_next = mid_reg - 1'b1;
                end
                else
                begin
                    head_next = mid_reg;
                end
                state_next = ST_SEARCH;
            end
            ST_DX:
            begin
                dx_next    = $signed({1'b0, pos_reg}) - $signed({1'b0, knot_rdata});
                state_next = ST_C3;
            end
            ST_C3:
            begin
                acc_next   = $signed(coef_rdata);
                pw_next    = POW_NEXT;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = acc_reg * dx_reg;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                acc_next = sum_sat;
                if (pw_reg == POW_LAST)
                begin
                    ok_next    = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    pw_next    = pw_reg - 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = ok_reg ? acc_reg : '0;
                    m_tuser_next  = M_TUSER_W'(ok_reg);
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        last_reg    <= last_next;
        head_reg    <= head_next;
        tail_reg    <= tail_next;
        mid_reg     <= mid_next;
        pos_reg     <= pos_next;
        klo_reg     <= klo_next;
        dx_reg      <= dx_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        pw_reg      <= pw_next;
        ok_reg      <= ok_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

### sv/cspl_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module cspl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### sv/cspl_checker.sv
// Port-level checker for the spline evaluator, bound to the top level.
`default_nettype none

module cspl_checker
    import cspl_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic [S_TUSER_W-1:0] s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A failed or write result carries a zero value
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("out-of-range result not zero");

    // Write beats answer in the next cycle
    a_write_answer: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser != CMD_EVAL
        |=> m_tvalid && !m_tuser[0] && m_tdata == '0)
        else $error("write beat not answered at once");

    // An evaluation blocks further beats while it runs
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == CMD_EVAL |=> !s_tready)
        else $error("beat taken during evaluation");

endmodule

bind cubic_spline_curve_evaluator cspl_checker u_cspl_checker (.*);

`default_nettype wire

### tb/cubic_spline_curve_evaluator_tb.sv
// Self-checking stream testbench for the cubic spline curve evaluator.
`timescale 1ns / 1ps

module cubic_spline_curve_evaluator_tb;
    import cspl_pkg::*;

    localparam int NUM_CURVES  = 4;
    localparam int MAX_KNOTS   = 8;
    localparam int RANDOM_BEATS = 1250;
    localparam int TAIL_CYCLES = 40;      // waits for any stray result after the drain
    localparam int IDLE_LIMIT  = 4000;    // covers the long output hold-off
    localparam int HOLD_CYCLES = 400;
    localparam longint VALUE_MAX = 64'sd2147483647;
    localparam longint VALUE_MIN = -64'sd2147483648;

    // One input beat plus, for directed rows, the result it must give.
    typedef struct packed {
        cmd_t        cmd;
        logic [1:0]  curve;
        logic [2:0]  idx;
        logic [1:0]  pow;
        logic [31:0] wv;
        logic [15:0] pos;
        logic        typed;
        logic [31:0] exp_value;
        logic        exp_in_range;
        logic        drain;
    } stim_item_t;

    typedef struct packed {
        logic [31:0] value;
        logic        in_range;
    } curve_result_t;

    // Directed rows. Curve 3 gets two knots and extreme coefficients
    // (a3 max, a2 min, a1 = 1.0, a0 = -1.0) so that the upper saturation rail is hit.
    localparam int DIRECTED_ROWS = 25;
    localparam stim_item_t DIRECTED_TAB [0:DIRECTED_ROWS-1] = '{
        // count zero after reset
        '{CMD_EVAL,      2'd0, 3'd0, 2'd0, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        // negative count clamps to zero
        '{CMD_SET_COUNT, 2'd1, 3'd0, 2'd0, 32'h8000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd1, 3'd0, 2'd0, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        // a single knot is not a curve
        '{CMD_SET_COUNT, 2'd2, 3'd0, 2'd0, 32'h0000_0001, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_WRITE_KNOT,2'd2, 3'd0, 2'd0, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd2, 3'd0, 2'd0, 32'h0000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        // knots 0 and 0xFFFF; upper bits of the write value are dropped
        '{CMD_WRITE_KNOT,2'd3, 3'd0, 2'd0, 32'hFFFF_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_WRITE_KNOT,2'd3, 3'd1, 2'd0, 32'h0000_FFFF, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_WRITE_COEF,2'd3, 3'd0, 2'd3, 32'h7FFF_FFFF, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_WRITE_COEF,2'd3, 3'd0, 2'd2, 32'h8000_0000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_WRITE_COEF,2'd3, 3'd0, 2'd1, 32'h0000_0100, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_WRITE_COEF,2'd3, 3'd0, 2'd0, 32'hFFFF_FF00, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_SET_COUNT, 2'd3, 3'd0, 2'd0, 32'h0000_0002, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        // at the first knot dx is zero, so the answer is a0
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'h0000, 1'b1, 32'hFFFF_FF00, 1'b1,
          1'b0},
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'hFFFF, 1'b0, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'h0800, 1'b0, 32'h0, 1'b0, 1'b0},
        // narrow the span and probe just outside both ends
        '{CMD_WRITE_KNOT,2'd3, 3'd0, 2'd0, 32'h0000_1000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'h0FFF, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'h1000, 1'b1, 32'hFFFF_FF00, 1'b1,
          1'b0},
        '{CMD_WRITE_KNOT,2'd3, 3'd1, 2'd0, 32'h0000_F000, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'hF001, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_EVAL,      2'd3, 3'd0, 2'd0, 32'h0000_0000, 16'hF000, 1'b0, 32'h0, 1'b0, 1'b0},
        // top entry index and top power
        '{CMD_WRITE_COEF,2'd3, 3'd7, 2'd3, 32'h5555_AAAA, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        // oversized counts clamp to the table depth
        '{CMD_SET_COUNT, 2'd1, 3'd0, 2'd0, 32'h7FFF_FFFF, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0},
        '{CMD_SET_COUNT, 2'd0, 3'd0, 2'd0, 32'h0000_0009, 16'h0000, 1'b1, 32'h0, 1'b0, 1'b0}
    };

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    cubic_spline_curve_evaluator #(
        .NUM_CURVES (NUM_CURVES),
        .MAX_KNOTS  (MAX_KNOTS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Beats to send, and the generator's record of which entries hold data
    stim_item_t stim_q[$];
    logic [15:0] gen_knot    [NUM_CURVES][MAX_KNOTS];
    bit          gen_knot_ok [NUM_CURVES][MAX_KNOTS];
    bit          gen_coef_ok [NUM_CURVES][MAX_KNOTS][4];
    int          gen_count   [NUM_CURVES];
    bit          pause_next;

    // Predictor state: the curve tables as the block should hold them
    logic        [15:0] curve_knots  [NUM_CURVES][MAX_KNOTS];
    logic signed [31:0] curve_coefs  [NUM_CURVES][MAX_KNOTS][4];
    int                 curve_counts [NUM_CURVES];

    curve_result_t expected_results_q[$];
    int beats_taken;
    int results_seen;
    int error_count;
    int idle_cycles;
    int n_eval_hits;
    int n_eval_misses;
    int n_writes;
    int n_pauses;

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("%s", msg);
    endtask

    function automatic int clamped_count(logic [31:0] wv);
        if (wv[31])
            return 0;
        if (wv > MAX_KNOTS)
            return MAX_KNOTS;
        return int'(wv);
    endfunction

    // Apply one accepted beat to the predicted tables and work out its result.
    function automatic curve_result_t predict_curve_value(stim_item_t it);
        curve_result_t res;
        int n;
        int head;
        int tail;
        int mid;
        longint dx;
        longint acc;
        res = '0;
        case (it.cmd)
            CMD_WRITE_KNOT: curve_knots[it.curve][it.idx] = it.wv[15:0];
            CMD_WRITE_COEF: curve_coefs[it.curve][it.idx][it.pow] = it.wv;
            CMD_SET_COUNT:  curve_counts[it.curve] = clamped_count(it.wv);
            default:
            begin
                n = curve_counts[it.curve];
                if (n >= 2 && it.pos >= curve_knots[it.curve][0]
                        && it.pos <= curve_knots[it.curve][n-1])
                begin
                    // binary search for the largest knot strictly below the position
                    head = 0;
                    tail = n - 1;
                    while (head < tail)
                    begin
                        mid = (head + tail) / 2 + 1;
                        if (it.pos <= curve_knots[it.curve][mid])
                            tail = mid - 1;
                        else
                            head = mid;
                    end
                    dx  = longint'(it.pos) - longint'(curve_knots[it.curve][head]);
                    acc = longint'(curve_coefs[it.curve][head][3]);
                    for (int p = 2; p >= 0; p--)
                    begin
                        acc = ((acc * dx) >>> FRAC_POS) + longint'(curve_coefs[it.curve][head][p]);
                        if (acc > VALUE_MAX)
                            acc = VALUE_MAX;
                        else if (acc < VALUE_MIN)
                            acc = VALUE_MIN;
                    end
                    res.value    = acc[31:0];
                    res.in_range = 1'b1;
                end
            end
        endcase
        return res;
    endfunction

    // True when evaluating the curve can only touch knots and coefficients
    // that have been written.
    function automatic bit eval_is_safe(int c);
        int n;
        n = gen_count[c];
        if (n < 2)
            return 1'b1;
        for (int j = 0; j < n; j++)
            if (!gen_knot_ok[c][j])
                return 1'b0;
        for (int s = 0; s < n - 1; s++)
            for (int p = 0; p < 4; p++)
                if (!gen_coef_ok[c][s][p])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic stim_item_t random_item(cmd_t cmd, int c);
        stim_item_t it;
        it       = '0;
        it.cmd   = cmd;
        it.curve = c;
        it.idx   = $urandom;
        it.pow   = $urandom;
        it.wv    = $urandom;
        it.pos   = $urandom;
        return it;
    endfunction

    function automatic logic [31:0] random_coef();
        int bits;
        logic [31:0] mag;
        if ($urandom_range(0, 4) == 0)
            return $urandom;
        bits = $urandom_range(1, 22);
        mag  = $urandom & ((32'd1 << bits) - 32'd1);
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    // Record what the beat writes, attach any pending pause, and queue it.
    task automatic queue_item(input stim_item_t it);
        it.drain   = pause_next;
        pause_next = 1'b0;
        case (it.cmd)
            CMD_WRITE_KNOT:
            begin
                gen_knot[it.curve][it.idx]    = it.wv[15:0];
                gen_knot_ok[it.curve][it.idx] = 1'b1;
            end
            CMD_WRITE_COEF: gen_coef_ok[it.curve][it.idx][it.pow] = 1'b1;
            CMD_SET_COUNT:  gen_count[it.curve] = clamped_count(it.wv);
            default: ;
        endcase
        stim_q.push_back(it);
    endtask

    // Checker: predict on every accepted input beat, compare every result beat.
    always @(posedge clk)
    begin : beat_monitor
        stim_item_t    taken;
        curve_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (expected_results_q.size() == 0)
                    flag_error($sformatf("result beat %0d arrived with nothing pending: %h/%b",
                                         results_seen, m_tdata, m_tuser[0]));
                else
                begin
                    want = expected_results_q.pop_front();
                    if (m_tdata !== want.value)
                        flag_error($sformatf("result beat %0d curve_value: expected %h got %h",
                                             results_seen, want.value, m_tdata));
                    if (m_tuser[0] !== want.in_range)
                        flag_error($sformatf("result beat %0d in_range: expected %b got %b",
                                             results_seen, want.in_range, m_tuser[0]));
                end
            end
            if (s_tvalid && s_tready)
            begin
                taken = stim_q[beats_taken];
                beats_taken++;
                want = predict_curve_value(taken);
                if (taken.cmd == CMD_EVAL)
                begin
                    if (want.in_range)
                        n_eval_hits++;
                    else
                        n_eval_misses++;
                end
                else
                    n_writes++;
                // directed rows carry their own answer
                if (taken.typed)
                begin
                    want.value    = taken.exp_value;
                    want.in_range = taken.exp_in_range;
                end
                expected_results_q.push_back(want);
            end
            // watchdog on cycles with no beat moving either way
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
                $display("[cubic_spline_curve_evaluator] ERROR");
                $finish;
            end
        end
    end

    // Result side: stall on a changing pattern, with one long hold-off
    // mid-run so the block fills up and pushes back on the input.
    initial
    begin : result_sink
        int  mode;
        int  span;
        bit  held;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && results_seen >= 500)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= $urandom_range(0, 1);
                    2:       m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        stim_item_t  it;
        logic [15:0] keys [MAX_KNOTS];
        logic [15:0] tmp;
        int c;
        int c2;
        int n;
        int r;
        int j;
        int lo;
        int hi;
        int evals;
        int gap;
        int burst_left;
        bit unsorted;

        beats_taken   = 0;
        results_seen  = 0;
        error_count   = 0;
        idle_cycles   = 0;
        n_eval_hits   = 0;
        n_eval_misses = 0;
        n_writes      = 0;
        n_pauses      = 0;
        pause_next    = 1'b0;
        for (int k = 0; k < NUM_CURVES; k++)
        begin
            gen_count[k]    = 0;
            curve_counts[k] = 0;
            for (int e = 0; e < MAX_KNOTS; e++)
            begin
                gen_knot_ok[k][e] = 1'b0;
                for (int p = 0; p < 4; p++)
                    gen_coef_ok[k][e][p] = 1'b0;
            end
        end

        for (int row = 0; row < DIRECTED_ROWS; row++)
            queue_item(DIRECTED_TAB[row]);

        // Random part: mostly load a curve properly then evaluate it,
        // with some stray single beats mixed in.
        pause_next = 1'b1;
        while (stim_q.size() < DIRECTED_ROWS + RANDOM_BEATS)
        begin
            if ($urandom_range(0, 24) == 0)
                pause_next = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                c        = $urandom_range(0, NUM_CURVES - 1);
                n        = $urandom_range(2, MAX_KNOTS);
                unsorted = ($urandom_range(0, 6) == 0);
                for (j = 0; j < n; j++)
                    keys[j] = $urandom;
                if (!unsorted)
                begin
                    for (j = 1; j < n; j++)
                        for (int m = j; m > 0 && keys[m-1] > keys[m]; m--)
                        begin
                            tmp       = keys[m];
                            keys[m]   = keys[m-1];
                            keys[m-1] = tmp;
                        end
                    if ($urandom_range(0, 5) == 0)
                    begin
                        keys[0]   = 16'h0000;
                        keys[n-1] = 16'hFFFF;
                    end
                end
                for (j = 0; j < n; j++)
                begin
                    it = random_item(CMD_WRITE_KNOT, c);
                    it.idx       = j;
                    it.wv[15:0]  = keys[j];
                    queue_item(it);
                end
                for (j = 0; j < n - 1; j++)
                    for (int p = 3; p >= 0; p--)
                    begin
                        it = random_item(CMD_WRITE_COEF, c);
                        it.idx = j;
                        it.pow = p;
                        it.wv  = random_coef();
                        queue_item(it);
                    end
                it = random_item(CMD_SET_COUNT, c);
                it.wv = n;
                queue_item(it);

                evals = $urandom_range(8, 30);
                repeat (evals)
                begin
                    c2 = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NUM_CURVES - 1) : c;
                    if (eval_is_safe(c2))
                    begin
                        it = random_item(CMD_EVAL, c2);
                        n  = gen_count[c2];
                        lo = (n >= 2) ? gen_knot[c2][0]   : 0;
                        hi = (n >= 2) ? gen_knot[c2][n-1] : 16'hFFFF;
                        r  = $urandom_range(0, 99);
                        if (r < 50)
                            it.pos = $urandom_range(lo, hi);
                        else if (r < 65 && n >= 2)
                            it.pos = gen_knot[c2][$urandom_range(0, n - 1)];
                        else if (r < 80)
                            it.pos = $urandom;
                        else if (r < 88)
                            it.pos = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                        else
                            it.pos = $urandom_range(0, 1) ? lo - 1 : hi + 1;
                        queue_item(it);
                    end
                end
            end
            else
            begin
                // stray beat: any command, any field
                c  = $urandom_range(0, NUM_CURVES - 1);
                it = random_item(cmd_t'($urandom_range(0, 3)), c);
                if (it.cmd == CMD_WRITE_COEF && $urandom_range(0, 1))
                    it.wv = random_coef();
                if (it.cmd == CMD_SET_COUNT && $urandom_range(0, 2) != 0)
                    it.wv = $urandom_range(0, MAX_KNOTS + 1);
                if (it.cmd != CMD_EVAL || eval_is_safe(c))
                    queue_item(it);
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Send in bursts; a pause beat first waits for every result to come back.
        burst_left = 0;
        for (int i = 0; i < stim_q.size(); i++)
        begin
            it = stim_q[i];
            if (it.drain)
            begin
                n_pauses++;
                s_tvalid <= 1'b0;
                @(negedge clk);
                while (results_seen != i)
                    @(negedge clk);
                @(posedge clk);
            end
            else if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 24);
                if (gap != 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            if (burst_left > 0)
                burst_left--;
            s_tvalid <= 1'b1;
            s_tdata  <= {1'b0, it.pos, it.wv, it.pow, it.idx, it.curve};
            s_tuser  <= it.cmd;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
        end
        s_tvalid <= 1'b0;

        // Drain, then give the block time to show any stray result.
        @(negedge clk);
        while (results_seen != stim_q.size())
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_results_q.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_results_q.size()));

        $display("covered %0d beats: %0d evaluations in range, %0d rejected, %0d table writes",
                 beats_taken, n_eval_hits, n_eval_misses, n_writes);
        $display("with %0d full pauses, one %0d-cycle output hold-off; %0d mismatches",
                 n_pauses, HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("[cubic_spline_curve_evaluator] OK");
        else
            $display("[cubic_spline_curve_evaluator] ERROR");
        $finish;
    end

endmodule

### sim.f
sv/cspl_pkg.sv
sv/cspl_ram.sv
sv/cubic_spline_curve_evaluator.sv
sv/cspl_checker.sv
tb/cubic_spline_curve_evaluator_tb.sv
